// File: rtl/dtd_pkg.sv
// ----------------------------------------------------------------------------
// dtd_pkg
// Shared types, record and error codes, and the crc-16 byte step for the
// disk image track decoder.
// ----------------------------------------------------------------------------
package dtd_pkg;

    localparam logic [15:0] CRC_POLY = 16'hA097;

    localparam logic [2:0] REC_TRACK  = 3'd0;
    localparam logic [2:0] REC_SECTOR = 3'd1;
    localparam logic [2:0] REC_LIT    = 3'd2;
    localparam logic [2:0] REC_RUN    = 3'd3;
    localparam logic [2:0] REC_SECEND = 3'd4;
    localparam logic [2:0] REC_END    = 3'd5;
    localparam logic [2:0] REC_ERROR  = 3'd6;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_TRACK_CRC = 4'd1;
    localparam logic [3:0] ERR_HDR_CRC   = 4'd2;
    localparam logic [3:0] ERR_ZERO_LEN  = 4'd3;
    localparam logic [3:0] ERR_BAD_MODE  = 4'd4;
    localparam logic [3:0] ERR_RAW_LEN   = 4'd5;
    localparam logic [3:0] ERR_PAT_FORM  = 4'd6;
    localparam logic [3:0] ERR_BLK_TYPE  = 4'd7;
    localparam logic [3:0] ERR_BLK_OVF   = 4'd8;
    localparam logic [3:0] ERR_SHORT     = 4'd9;
    localparam logic [3:0] ERR_DATA_CRC  = 4'd10;

    localparam logic [7:0] END_MARK  = 8'hFF;
    localparam logic [7:0] FILL_F6   = 8'hF6;
    localparam logic [7:0] FILL_ZERO = 8'h00;

    typedef struct packed {
        logic [2:0]  record;
        logic [7:0]  track_cylinder;
        logic [6:0]  track_head;
        logic [7:0]  id_cylinder;
        logic [7:0]  id_head;
        logic [7:0]  id_sector;
        logic [7:0]  size_code;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
        logic [15:0] run_length;
        logic [4:0]  sector_marks;
        logic [3:0]  error_code;
    } t_rec;

    typedef struct packed {
        logic take;
        logic push;
        logic err;
    } t_dec_ctl;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            x = x[15] ? ({x[14:0], 1'b0} ^ CRC_POLY) : {x[14:0], 1'b0};
        end
        return x;
    endfunction

endpackage

// File: rtl/dtd_in_queue.sv
// ----------------------------------------------------------------------------
// dtd_in_queue
// Two-entry byte queue at the input side; decouples the image byte stream
// from the decoder.
// ----------------------------------------------------------------------------
module dtd_in_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_byte,
    output logic       o_full,
    output logic       o_valid,
    output logic [7:0] o_byte,
    input  logic       i_take
);
    logic [7:0] r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_byte  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end
endmodule

// File: rtl/dtd_out_queue.sv
// ----------------------------------------------------------------------------
// dtd_out_queue
// Four-entry record queue at the result side.
// ----------------------------------------------------------------------------
module dtd_out_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dtd_pkg::t_rec i_rec,
    output logic          o_full,
    output logic          o_empty,
    output dtd_pkg::t_rec o_rec,
    input  logic          i_pop
);
    dtd_pkg::t_rec r_mem [4];
    logic [1:0]    r_wp, r_rp;
    logic [2:0]    r_cnt;
    logic          w_wr, w_rd;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_rec   = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (w_wr) r_wp <= r_wp + 2'd1;
            if (w_rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, w_wr} - {2'b0, w_rd};
        end
    end
endmodule

// File: rtl/dtd_decoder.sv
// ----------------------------------------------------------------------------
// dtd_decoder
// Track and sector parser: takes one byte at a time, keeps the header and
// data crcs and, while the result queue is not full, folds pattern runs one
// byte per cycle and emits at most one record per cycle into that queue.
// ----------------------------------------------------------------------------
module dtd_decoder #(
    parameter int MAX_SIZE_CODE = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_data_rate,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_out_full,
    output dtd_pkg::t_dec_ctl o_ctl,
    output dtd_pkg::t_rec     o_rec
);
    localparam int SIZE_W = MAX_SIZE_CODE + 10;
    localparam int CW     = (SIZE_W > 17) ? SIZE_W + 1 : 18;

    typedef enum logic [10:0] {
        PH_TRK_FIRST = 11'b00000000001,
        PH_TRK_REST  = 11'b00000000010,
        PH_SEC_HDR   = 11'b00000000100,
        PH_LEN       = 11'b00000001000,
        PH_RAW       = 11'b00000010000,
        PH_PAT_HDR   = 11'b00000100000,
        PH_BLK_TYPE  = 11'b00001000000,
        PH_BLK_REP   = 11'b00010000000,
        PH_BLK_LIT   = 11'b00100000000,
        PH_BLK_PAT   = 11'b01000000000,
        PH_DONE      = 11'b10000000000
    } t_phase;

    typedef enum logic [4:0] {
        C_NONE    = 5'b00001,
        C_FILL    = 5'b00010,
        C_SECDONE = 5'b00100,
        C_ENDSEC  = 5'b01000,
        C_AFTER   = 5'b10000
    } t_cont;

    t_phase            r_phase, n_phase;
    t_cont             r_cont, n_cont;
    logic [2:0]        r_cnt, n_cnt;
    logic [7:0]        r_hb [6];
    logic [7:0]        n_hb [6];
    logic [7:0]        r_secleft, n_secleft;
    logic [7:0]        r_cyl, n_cyl;
    logic [6:0]        r_head, n_head;
    logic              r_fm, n_fm;
    logic [15:0]       r_hcrc, n_hcrc;
    logic [15:0]       r_ca, n_ca;
    logic [15:0]       r_cc, n_cc;
    logic [15:0]       r_blk, n_blk;
    logic [SIZE_W-1:0] r_prod, n_prod;
    logic [7:0]        r_run, n_run;
    logic [15:0]       r_pat, n_pat;
    logic              r_err, n_err;
    logic [SIZE_W-1:0] r_fold, n_fold;

    logic [SIZE_W-1:0] w_size;
    logic [7:0]        w_fb;
    logic              v_take, v_push, v_after, v_endsec, v_secdone, v_fail;
    logic [2:0]        v_kind;
    logic [7:0]        v_a, v_b;
    logic [15:0]       v_run, v_blk;
    logic [3:0]        v_ecode;
    logic              w_sec;

    assign w_size = (r_hb[3] <= 8'(MAX_SIZE_CODE))
                  ? ({{(SIZE_W-8){1'b0}}, 8'd128} << r_hb[3][2:0]) : '0;
    assign w_fb   = r_fold[0] ? r_pat[15:8] : r_pat[7:0];

    always_comb begin
        n_phase = r_phase;  n_cont = r_cont;  n_cnt = r_cnt;  n_hb = r_hb;
        n_secleft = r_secleft;  n_cyl = r_cyl;  n_head = r_head;  n_fm = r_fm;
        n_hcrc = r_hcrc;  n_ca = r_ca;  n_cc = r_cc;  n_blk = r_blk;
        n_prod = r_prod;  n_run = r_run;  n_pat = r_pat;  n_err = r_err;
        n_fold = r_fold;
        v_take = 1'b0;  v_push = 1'b0;  v_after = 1'b0;  v_endsec = 1'b0;
        v_secdone = 1'b0;  v_fail = 1'b0;  v_kind = dtd_pkg::REC_TRACK;
        v_a = 8'h00;  v_b = 8'h00;  v_run = 16'h0000;  v_ecode = dtd_pkg::ERR_NONE;
        v_blk = r_blk;

        if (!i_out_full) begin
            if (r_fold != '0) begin
                n_ca   = dtd_pkg::crc_byte(r_ca, w_fb);
                n_cc   = dtd_pkg::crc_byte(r_cc, w_fb);
                n_fold = r_fold - 1'b1;
            end else if (r_cont != C_NONE) begin
                n_cont = C_NONE;
                unique case (r_cont)
                    C_FILL: begin
                        if (r_hb[5] != r_hcrc[7:0]) begin
                            v_fail = 1'b1;  v_ecode = dtd_pkg::ERR_HDR_CRC;
                        end else begin
                            v_push = 1'b1;  v_kind = dtd_pkg::REC_RUN;
                            v_a = r_hb[4][4] ? dtd_pkg::FILL_F6 : dtd_pkg::FILL_ZERO;
                            v_b = v_a;
                            v_run = 16'(w_size >> 1);
                            n_cont = C_SECDONE;
                        end
                    end
                    C_SECDONE: v_secdone = 1'b1;
                    C_ENDSEC:  v_endsec = 1'b1;
                    C_AFTER:   v_after = 1'b1;
                    default:   n_cont = C_NONE;
                endcase
            end else if (i_valid) begin
                v_take = 1'b1;
                if (!r_err) begin
                    unique case (r_phase)
                        PH_TRK_FIRST: begin
                            if (i_byte == dtd_pkg::END_MARK) begin
                                v_push = 1'b1;  v_kind = dtd_pkg::REC_END;
                                n_phase = PH_DONE;
                            end else begin
                                n_hb[0] = i_byte;
                                n_hcrc  = dtd_pkg::crc_byte(16'h0000, i_byte);
                                n_cnt   = 3'd1;
                                n_phase = PH_TRK_REST;
                            end
                        end
                        PH_TRK_REST: begin
                            n_hb[r_cnt] = i_byte;
                            n_cnt = r_cnt + 3'd1;
                            if (r_cnt != 3'd3) begin
                                n_hcrc = dtd_pkg::crc_byte(r_hcrc, i_byte);
                            end else begin
                                n_cnt = 3'd0;
                                if (i_byte != r_hcrc[7:0]) begin
                                    v_fail = 1'b1;  v_ecode = dtd_pkg::ERR_TRACK_CRC;
                                end else begin
                                    n_secleft = r_hb[0];
                                    n_cyl     = r_hb[1];
                                    n_head    = r_hb[2][6:0];
                                    n_fm      = r_hb[2][7];
                                    v_push = 1'b1;  v_kind = dtd_pkg::REC_TRACK;
                                    n_phase = (r_hb[0] != 8'h00) ? PH_SEC_HDR : PH_TRK_FIRST;
                                end
                            end
                        end
                        PH_SEC_HDR: begin
                            n_hb[r_cnt] = i_byte;
                            n_cnt = r_cnt + 3'd1;
                            if (r_cnt == 3'd0) begin
                                n_hcrc = dtd_pkg::crc_byte(16'h0000, i_byte);
                            end else if (r_cnt != 3'd5) begin
                                n_hcrc = dtd_pkg::crc_byte(r_hcrc, i_byte);
                            end else begin
                                n_cnt = 3'd0;
                                v_push = 1'b1;  v_kind = dtd_pkg::REC_SECTOR;
                                if (r_hb[4][5:4] != 2'b00) begin
                                    n_cont = C_FILL;
                                end else begin
                                    n_ca = 16'h0000;  n_cc = r_hcrc;
                                    n_prod = '0;  n_blk = 16'h0000;
                                    if (r_hb[3] <= 8'(MAX_SIZE_CODE)) n_phase = PH_LEN;
                                    else n_cont = C_ENDSEC;
                                end
                            end
                        end
                        PH_LEN: begin
                            if (r_cnt == 3'd0) begin
                                n_blk = {8'h00, i_byte};  n_cnt = 3'd1;
                            end else if (r_cnt == 3'd1) begin
                                n_blk = {i_byte, r_blk[7:0]};  n_cnt = 3'd2;
                            end else begin
                                n_cnt = 3'd0;
                                if (r_blk == 16'h0000) begin
                                    v_fail = 1'b1;  v_ecode = dtd_pkg::ERR_ZERO_LEN;
                                end else begin
                                    n_blk = r_blk - 16'd1;
                                    v_blk = n_blk;
                                    case (i_byte)
                                        8'd0: begin
                                            if (CW'(n_blk) != CW'(w_size)) begin
                                                v_fail = 1'b1;  v_ecode = dtd_pkg::ERR_RAW_LEN;
                                            end else n_phase = PH_RAW;
                                        end
                                        8'd1: begin
                                            if (n_blk != 16'd4) begin
                                                v_fail = 1'b1;  v_ecode = dtd_pkg::ERR_PAT_FORM;
                                            end else n_phase = PH_PAT_HDR;
                                        end
                                        8'd2: v_after = 1'b1;
                                        default: begin
                                            v_fail = 1'b1;  v_ecode = dtd_pkg::ERR_BAD_MODE;
                                        end
                                    endcase
                                end
                            end
                        end
                        PH_RAW: begin
                            v_push = 1'b1;  v_kind = dtd_pkg::REC_LIT;  v_a = i_byte;
                            n_ca = dtd_pkg::crc_byte(r_ca, i_byte);
                            n_cc = dtd_pkg::crc_byte(r_cc, i_byte);
                            n_prod = r_prod + 1'b1;
                            if (CW'(n_prod) >= CW'(w_size)) n_cont = C_ENDSEC;
                        end
                        PH_PAT_HDR: begin
                            n_cnt = r_cnt + 3'd1;
                            case (r_cnt)
                                3'd0: n_blk = {8'h00, i_byte};
                                3'd1: n_blk = {i_byte, r_blk[7:0]};
                                3'd2: n_pat = {8'h00, i_byte};
                                default: begin
                                    n_pat = {i_byte, r_pat[7:0]};
                                    n_cnt = 3'd0;
                                    if (CW'({r_blk, 1'b0}) != CW'(w_size)) begin
                                        v_fail = 1'b1;  v_ecode = dtd_pkg::ERR_PAT_FORM;
                                    end else begin
                                        n_blk = 16'h0000;
                                        v_push = 1'b1;  v_kind = dtd_pkg::REC_RUN;
                                        v_a = r_pat[7:0];  v_b = i_byte;  v_run = r_blk;
                                        n_prod = r_prod + w_size;
                                        n_fold = w_size;
                                        n_cont = C_ENDSEC;
                                    end
                                end
                            endcase
                        end
                        PH_BLK_TYPE: begin
                            n_run = i_byte;
                            n_blk = r_blk - 16'd2;
                            n_phase = PH_BLK_REP;
                        end
                        PH_BLK_REP: begin
                            if (r_run == 8'd0) begin
                                if ({8'h00, i_byte} > r_blk
                                    || CW'(r_prod) + CW'(i_byte) > CW'(w_size)) begin
                                    v_fail = 1'b1;  v_ecode = dtd_pkg::ERR_BLK_OVF;
                                end else begin
                                    n_blk = r_blk - {8'h00, i_byte};
                                    n_run = i_byte;
                                    if (i_byte == 8'd0) v_after = 1'b1;
                                    else n_phase = PH_BLK_LIT;
                                end
                            end else if (r_run == 8'd1) begin
                                if (r_blk < 16'd2
                                    || CW'(r_prod) + CW'({i_byte, 1'b0}) > CW'(w_size)) begin
                                    v_fail = 1'b1;  v_ecode = dtd_pkg::ERR_BLK_OVF;
                                end else begin
                                    n_blk = r_blk - 16'd2;
                                    n_run = i_byte;
                                    n_cnt = 3'd0;
                                    n_phase = PH_BLK_PAT;
                                end
                            end else begin
                                v_fail = 1'b1;  v_ecode = dtd_pkg::ERR_BLK_TYPE;
                            end
                        end
                        PH_BLK_LIT: begin
                            v_push = 1'b1;  v_kind = dtd_pkg::REC_LIT;  v_a = i_byte;
                            n_ca = dtd_pkg::crc_byte(r_ca, i_byte);
                            n_cc = dtd_pkg::crc_byte(r_cc, i_byte);
                            n_prod = r_prod + 1'b1;
                            n_run = r_run - 8'd1;
                            if (n_run == 8'd0) n_cont = C_AFTER;
                        end
                        PH_BLK_PAT: begin
                            if (r_cnt == 3'd0) begin
                                n_pat = {8'h00, i_byte};  n_cnt = 3'd1;
                            end else begin
                                n_pat = {i_byte, r_pat[7:0]};
                                n_cnt = 3'd0;
                                n_run = 8'd0;
                                if (r_run != 8'd0) begin
                                    v_push = 1'b1;  v_kind = dtd_pkg::REC_RUN;
                                    v_a = r_pat[7:0];  v_b = i_byte;  v_run = {8'h00, r_run};
                                    n_prod = r_prod + SIZE_W'({r_run, 1'b0});
                                    n_fold = SIZE_W'({r_run, 1'b0});
                                    n_cont = C_AFTER;
                                end else begin
                                    v_after = 1'b1;
                                end
                            end
                        end
                        PH_DONE: n_phase = PH_DONE;
                        default: n_phase = PH_DONE;
                    endcase
                end
            end

            if (v_after) begin
                if (v_blk == 16'h0000) begin
                    if (CW'(r_prod) < CW'(w_size)) begin
                        v_fail = 1'b1;  v_ecode = dtd_pkg::ERR_SHORT;
                    end else v_endsec = 1'b1;
                end else if (v_blk < 16'd2) begin
                    v_fail = 1'b1;  v_ecode = dtd_pkg::ERR_BLK_OVF;
                end else begin
                    n_phase = PH_BLK_TYPE;
                end
            end
            if (v_endsec) begin
                if (r_hb[5] != r_ca[7:0] && r_hb[5] != r_cc[7:0]) begin
                    v_fail = 1'b1;  v_ecode = dtd_pkg::ERR_DATA_CRC;
                end else v_secdone = 1'b1;
            end
            if (v_secdone) begin
                v_push = 1'b1;  v_kind = dtd_pkg::REC_SECEND;
                n_secleft = r_secleft - 8'd1;
                n_cnt = 3'd0;
                n_phase = (n_secleft != 8'd0) ? PH_SEC_HDR : PH_TRK_FIRST;
            end
            if (v_fail) begin
                v_push = 1'b1;  v_kind = dtd_pkg::REC_ERROR;
                v_a = 8'h00;  v_b = 8'h00;  v_run = 16'h0000;
                n_err = 1'b1;
                n_cont = C_NONE;
            end
        end
    end

    assign w_sec = (v_kind == dtd_pkg::REC_SECTOR) || (v_kind == dtd_pkg::REC_LIT)
                || (v_kind == dtd_pkg::REC_RUN) || (v_kind == dtd_pkg::REC_SECEND);

    always_comb begin
        o_rec = '0;
        o_rec.record         = v_kind;
        o_rec.track_cylinder = n_cyl;
        o_rec.track_head     = n_head;
        o_rec.byte_a         = v_a;
        o_rec.byte_b         = v_b;
        o_rec.run_length     = v_run;
        o_rec.error_code     = v_ecode;
        if (w_sec) begin
            o_rec.id_cylinder  = r_hb[0];
            o_rec.id_head      = r_hb[1];
            o_rec.id_sector    = r_hb[2];
            o_rec.size_code    = r_hb[3];
            o_rec.sector_marks = {(r_hb[4][5:4] == 2'b00) && r_hb[4][6], r_hb[4][2],
                                  r_hb[4][1], i_data_rate[6:0] == 7'd2,
                                  i_data_rate[7] || n_fm};
        end
    end

    assign o_ctl.take = v_take;
    assign o_ctl.push = v_push;
    assign o_ctl.err  = r_err;

    always_ff @(posedge i_clk) begin
        r_hb  <= n_hb;
        r_pat <= n_pat;
        r_run <= n_run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TRK_FIRST;
            r_cont    <= C_NONE;
            r_cnt     <= 3'd0;
            r_secleft <= 8'd0;
            r_cyl     <= 8'd0;
            r_head    <= 7'd0;
            r_fm      <= 1'b0;
            r_hcrc    <= 16'h0000;
            r_ca      <= 16'h0000;
            r_cc      <= 16'h0000;
            r_blk     <= 16'h0000;
            r_prod    <= '0;
            r_err     <= 1'b0;
            r_fold    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_cont    <= n_cont;
            r_cnt     <= n_cnt;
            r_secleft <= n_secleft;
            r_cyl     <= n_cyl;
            r_head    <= n_head;
            r_fm      <= n_fm;
            r_hcrc    <= n_hcrc;
            r_ca      <= n_ca;
            r_cc      <= n_cc;
            r_blk     <= n_blk;
            r_prod    <= n_prod;
            r_err     <= n_err;
            r_fold    <= n_fold;
        end
    end
endmodule

// File: rtl/disk_image_track_decoder_core.sv
// ----------------------------------------------------------------------------
// disk_image_track_decoder_core
// An item is registered in the input queue, and its records in the result queue.
// An item can give up to two extra records, and the crc folding unit takes
// pattern repetitions a byte a cycle while the result queue is not full.
// Reset is synchronous: queues empty, parser waits for a track header,
// rate register zero.
// ----------------------------------------------------------------------------
module disk_image_track_decoder_core #(
    parameter int MAX_SIZE_CODE = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_stream_byte,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [2:0]  o_record,
    output logic [7:0]  o_track_cylinder,
    output logic [6:0]  o_track_head,
    output logic [7:0]  o_id_cylinder,
    output logic [7:0]  o_id_head,
    output logic [7:0]  o_id_sector,
    output logic [7:0]  o_size_code,
    output logic [7:0]  o_byte_a,
    output logic [7:0]  o_byte_b,
    output logic [15:0] o_run_length,
    output logic [4:0]  o_sector_marks,
    output logic [3:0]  o_error_code
);
    logic              r_data_rate;
    logic [7:0]        r_rate;
    logic              w_in_valid, w_out_full;
    logic [7:0]        w_in_byte;
    dtd_pkg::t_dec_ctl w_ctl;
    dtd_pkg::t_rec     w_dec_rec, w_out_rec;

    assign r_data_rate = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= 8'h00;
        end else if (i_cfg_we) begin
            r_rate <= i_cfg_wdata;
        end
    end

    dtd_in_queue u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_byte  (i_stream_byte),
        .o_full  (o_full),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte),
        .i_take  (w_ctl.take)
    );

    dtd_decoder #(.MAX_SIZE_CODE(MAX_SIZE_CODE)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_rate (r_rate),
        .i_valid     (w_in_valid),
        .i_byte      (w_in_byte),
        .i_out_full  (w_out_full | r_data_rate),
        .o_ctl       (w_ctl),
        .o_rec       (w_dec_rec)
    );

    dtd_out_queue u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_ctl.push),
        .i_rec   (w_dec_rec),
        .o_full  (w_out_full),
        .o_empty (o_empty),
        .o_rec   (w_out_rec),
        .i_pop   (i_pop)
    );

    assign o_record         = w_out_rec.record;
    assign o_track_cylinder = w_out_rec.track_cylinder;
    assign o_track_head     = w_out_rec.track_head;
    assign o_id_cylinder    = w_out_rec.id_cylinder;
    assign o_id_head        = w_out_rec.id_head;
    assign o_id_sector      = w_out_rec.id_sector;
    assign o_size_code      = w_out_rec.size_code;
    assign o_byte_a         = w_out_rec.byte_a;
    assign o_byte_b         = w_out_rec.byte_b;
    assign o_run_length     = w_out_rec.run_length;
    assign o_sector_marks   = w_out_rec.sector_marks;
    assign o_error_code     = w_out_rec.error_code;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.push && w_out_full))
        else $error("record pushed into full queue");

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.take |-> w_in_valid)
        else $error("byte taken from empty queue");

    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.err && $past(w_ctl.err)) |-> !w_ctl.push)
        else $error("record after error");
endmodule
